// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define PCIELF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication, masked while reset is held.
`define PCIELF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- rtl/pcielf_pkg.sv -----
package pcielf_pkg;

    localparam int CNT_W   = 32;
    localparam int MAX_NTS = 3;

    // Configuration register indexes
    localparam logic CFG_REQ_GEN   = 1'b0;
    localparam logic CFG_REQ_WIDTH = 1'b1;

    // Notification codes
    typedef enum logic [3:0] {
        NT_MACUP   = 4'd0,
        NT_LINKUP  = 4'd1,
        NT_LINKDN  = 4'd2,
        NT_HOSTUP  = 4'd3,
        NT_HOSTDN  = 4'd4,
        NT_BUSCHG  = 4'd5,
        NT_FAULT   = 4'd6,
        NT_SERDES  = 4'd7,
        NT_POWERDN = 4'd8,
        NT_NONE    = 4'd9
    } t_note;

    // Port state codes as seen on the output
    localparam logic [2:0] PS_OFF   = 3'd0;
    localparam logic [2:0] PS_FAULT = 3'd5;

    // One classified event: its notifications and the resulting state
    typedef struct packed {
        logic [1:0]                       num;
        t_note [MAX_NTS-1:0]              notes;
        logic [MAX_NTS-1:0][CNT_W-1:0]    counts;
        logic [2:0]                       pstate;
    } t_plan;

    // Queue status toward front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic t_plan plan_add(t_plan p, t_note nt, logic [CNT_W-1:0] c);
        t_plan r;
        r = p;
        if (p.num < 2'd3) begin
            r.notes[p.num]  = nt;
            r.counts[p.num] = c;
            r.num           = p.num + 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/pcie_port_link_fsm_top.sv -----
// The first notification of an event passes through the queue, written at the edge that
// takes the event request, and then through the output register, loaded from the queue head.
// Throughput: 1 to 3 notifications per event, one per cycle from the output register while
// the receiver is ready; a new event is taken every cycle while the 2-entry queue between
// front and back has room, so the sustained rate is set by the back end.
// Reset (synchronous, active low) clears port state, bus, counters, config and the queue.
module pcie_port_link_fsm_top
    import pcielf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_kind,
    input  logic              i_gate_ok,
    input  logic [2:0]        i_link_gen,
    input  logic [5:0]        i_link_width,
    input  logic [7:0]        i_bus_number,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_note,
    output logic [CNT_W-1:0]  o_note_count,
    output logic [2:0]        o_port_state,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data
);

    t_plan     w_plan;
    t_plan     w_head;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    pcielf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_gate_ok    (i_gate_ok),
        .i_link_gen   (i_link_gen),
        .i_link_width (i_link_width),
        .i_bus_number (i_bus_number),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_plan       (w_plan)
    );

    pcielf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_plan   (w_plan),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    pcielf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_note       (o_note),
        .o_note_count (o_note_count),
        .o_port_state (o_port_state),
        .o_last       (o_last)
    );

endmodule

// ----- rtl/pcielf_front.sv -----
module pcielf_front
    import pcielf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_kind,
    input  logic              i_gate_ok,
    input  logic [2:0]        i_link_gen,
    input  logic [5:0]        i_link_width,
    input  logic [7:0]        i_bus_number,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_plan             o_plan
);

    typedef enum logic [2:0] {
        ST_OFF    = 3'd0,
        ST_DOWN   = 3'd1,
        ST_MACUP  = 3'd2,
        ST_LINKUP = 3'd3,
        ST_UP     = 3'd4,
        ST_FAULT  = 3'd5
    } t_state;

    typedef enum logic [2:0] {
        EV_MACDN  = 3'd0,
        EV_MACUP  = 3'd1,
        EV_LINKDN = 3'd2,
        EV_LINKUP = 3'd3,
        EV_BUSCHG = 3'd4,
        EV_PWRDN  = 3'd5
    } t_event;

    t_state             r_state, n_state;
    logic [7:0]         r_bus, n_bus;
    logic [CNT_W-1:0]   r_mac, n_mac;
    logic [CNT_W-1:0]   r_link, n_link;
    logic [CNT_W-1:0]   r_host, n_host;
    logic [CNT_W-1:0]   r_fault, n_fault;
    logic [2:0]         r_req_gen;
    logic [5:0]         r_req_width;
    logic               w_accept;
    logic               w_fault;
    logic               w_serdes;
    t_plan              w_plan;

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept;
    assign o_plan     = w_plan;

    assign w_serdes = ((r_req_gen != 3'd0) && (i_link_gen < r_req_gen)) ||
                      ((r_req_width != 6'd0) && (i_link_width < r_req_width));

    // Transition table and notification list for the offered event
    always_comb begin
        n_state = r_state;
        n_bus   = r_bus;
        n_mac   = r_mac;
        n_link  = r_link;
        n_host  = r_host;
        n_fault = r_fault;
        w_fault = 1'b0;
        w_plan  = '0;
        case (r_state)
            ST_OFF, ST_DOWN: begin
                if (i_kind == EV_MACUP) begin
                    n_state = ST_MACUP;
                    n_mac   = r_mac + 1'b1;
                    w_plan  = plan_add(w_plan, NT_MACUP, n_mac);
                end else if (i_kind == EV_LINKUP) begin
                    w_fault = 1'b1;
                end else if (i_kind == EV_PWRDN && r_state == ST_DOWN) begin
                    n_state = ST_OFF;
                    w_plan  = plan_add(w_plan, NT_POWERDN, '0);
                end
            end
            ST_MACUP: begin
                if (i_kind == EV_MACDN) begin
                    n_state = ST_DOWN;
                end else if (i_kind == EV_MACUP) begin
                    w_fault = 1'b1;
                end else if (i_kind == EV_LINKUP) begin
                    n_state = ST_LINKUP;
                    if (!i_gate_ok) begin
                        w_fault = 1'b1;
                    end else begin
                        n_bus  = i_bus_number;
                        n_link = r_link + 1'b1;
                        w_plan = plan_add(w_plan, NT_LINKUP, n_link);
                        if (w_serdes) begin
                            w_plan = plan_add(w_plan, NT_SERDES, '0);
                        end
                    end
                end else if (i_kind == EV_PWRDN) begin
                    n_state = ST_OFF;
                    w_plan  = plan_add(w_plan, NT_POWERDN, '0);
                end
            end
            ST_LINKUP: begin
                if (i_kind == EV_MACDN) begin
                    n_state = ST_DOWN;
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                end else if (i_kind == EV_MACUP) begin
                    w_fault = 1'b1;
                end else if (i_kind == EV_LINKDN) begin
                    n_state = ST_MACUP;
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                end else if (i_kind == EV_BUSCHG) begin
                    n_state = ST_UP;
                    n_bus   = i_bus_number;
                    if (i_bus_number != 8'd0 && i_bus_number != r_bus) begin
                        w_plan = plan_add(w_plan, NT_BUSCHG, '0);
                    end
                    n_host = r_host + 1'b1;
                    w_plan = plan_add(w_plan, NT_HOSTUP, n_host);
                end else if (i_kind == EV_PWRDN) begin
                    n_state = ST_OFF;
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                    w_plan  = plan_add(w_plan, NT_POWERDN, '0);
                end
            end
            ST_UP: begin
                if (i_kind == EV_MACDN) begin
                    n_state = ST_DOWN;
                    n_bus   = 8'd0;
                    w_plan  = plan_add(w_plan, NT_HOSTDN, r_host);
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                end else if (i_kind == EV_MACUP || i_kind == EV_LINKUP) begin
                    w_fault = 1'b1;
                end else if (i_kind == EV_LINKDN) begin
                    n_state = ST_MACUP;
                    n_bus   = 8'd0;
                    w_plan  = plan_add(w_plan, NT_HOSTDN, r_host);
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                end else if (i_kind == EV_BUSCHG) begin
                    n_bus = i_bus_number;
                    if (i_bus_number != 8'd0 && i_bus_number != r_bus) begin
                        w_plan = plan_add(w_plan, NT_BUSCHG, '0);
                    end
                end else if (i_kind == EV_PWRDN) begin
                    n_state = ST_OFF;
                    n_bus   = 8'd0;
                    w_plan  = plan_add(w_plan, NT_HOSTDN, r_host);
                    w_plan  = plan_add(w_plan, NT_LINKDN, r_link);
                    w_plan  = plan_add(w_plan, NT_POWERDN, '0);
                end
            end
            default: begin
                if (i_kind == EV_MACDN) begin
                    n_state = ST_DOWN;
                end else if (i_kind == EV_PWRDN) begin
                    n_state = ST_OFF;
                    w_plan  = plan_add(w_plan, NT_POWERDN, '0);
                end
            end
        endcase

        // Invalid transition: always ends the action chain
        if (w_fault) begin
            n_fault = r_fault + 1'b1;
            if (n_state != ST_FAULT) begin
                n_state = ST_FAULT;
                w_plan  = plan_add(w_plan, NT_FAULT, n_fault);
            end
        end

        if (w_plan.num == 2'd0) begin
            w_plan = plan_add(w_plan, NT_NONE, '0);
        end
        w_plan.pstate = n_state;
    end

    // Port state, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_OFF;
            r_bus       <= 8'd0;
            r_mac       <= '0;
            r_link      <= '0;
            r_host      <= '0;
            r_fault     <= '0;
            r_req_gen   <= 3'd0;
            r_req_width <= 6'd0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_bus   <= n_bus;
                r_mac   <= n_mac;
                r_link  <= n_link;
                r_host  <= n_host;
                r_fault <= n_fault;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REQ_GEN:   r_req_gen   <= i_cfg_data[2:0];
                    CFG_REQ_WIDTH: r_req_width <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/pcielf_queue.sv -----
module pcielf_queue
    import pcielf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_plan     i_plan,
    input  logic      i_pop,
    output t_plan     o_head,
    output t_q_status o_status
);

    t_plan      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/pcielf_back.sv -----
module pcielf_back
    import pcielf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_plan             i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_note,
    output logic [CNT_W-1:0]  o_note_count,
    output logic [2:0]        o_port_state,
    output logic              o_last
);

    logic               r_valid;
    logic [1:0]         r_idx;
    t_note              r_note;
    logic [CNT_W-1:0]   r_count;
    logic [2:0]         r_pstate;
    logic               r_last;
    logic               w_load;
    logic               w_take;
    logic               w_end;

    // Output slot refills when empty or when its request is taken
    assign w_load = !r_valid || i_out_ready;
    assign w_take = w_load && !i_q_status.empty;
    assign w_end  = (r_idx == (i_head.num - 2'd1));
    assign o_pop  = w_take && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= !i_q_status.empty;
            end
            if (w_take) begin
                r_idx <= w_end ? 2'd0 : (r_idx + 2'd1);
            end
        end
    end

    // Result payload, one notification per cycle while the slot refills from a non-empty queue
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_note   <= i_head.notes[r_idx];
            r_count  <= i_head.counts[r_idx];
            r_pstate <= i_head.pstate;
            r_last   <= w_end;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_note       = r_note;
    assign o_note_count = r_count;
    assign o_port_state = r_pstate;
    assign o_last       = r_last;

endmodule

// ----- rtl/pcielf_checker.sv -----
`include "assert_macros.svh"

module pcielf_checker
    import pcielf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [3:0]        o_note,
    input logic [CNT_W-1:0]  o_note_count,
    input logic [2:0]        o_port_state,
    input logic              o_last
);

    // Stalled request holds its payload
    `PCIELF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_note) && $stable(o_note_count) && $stable(o_last))

    // Empty step: a single closing request with no count
    `PCIELF_ASSERT_IMP(a_none, i_clk, i_rst_n, o_out_valid && o_note == NT_NONE, o_last && o_note_count == '0)

    // Fault notification leaves the port in fault and ends the step
    `PCIELF_ASSERT_IMP(a_fault, i_clk, i_rst_n, o_out_valid && o_note == NT_FAULT, o_port_state == PS_FAULT && o_last)

    // Power down always closes the step in the off state
    `PCIELF_ASSERT_IMP(a_pwrdn, i_clk, i_rst_n, o_out_valid && o_note == NT_POWERDN, o_port_state == PS_OFF && o_last && o_note_count == '0)

endmodule

bind pcie_port_link_fsm_top pcielf_checker u_checker (.*);

// ----- tb/pcie_port_link_fsm_top_test.sv -----
module pcie_port_link_fsm_top_test;
    import pcielf_pkg::*;

    // Port states and event kinds as the block encodes them
    typedef enum logic [2:0] {
        P_OFF    = 3'd0,
        P_DOWN   = 3'd1,
        P_MACUP  = 3'd2,
        P_LINKUP = 3'd3,
        P_UP     = 3'd4,
        P_FAULT  = 3'd5
    } t_port_st;

    typedef enum logic [2:0] {
        EV_MACDN  = 3'd0,
        EV_MACUP  = 3'd1,
        EV_LINKDN = 3'd2,
        EV_LINKUP = 3'd3,
        EV_BUSCHG = 3'd4,
        EV_PWRDN  = 3'd5,
        EV_RSVD6  = 3'd6,
        EV_RSVD7  = 3'd7
    } t_ev;

    typedef struct packed {
        t_ev        kind;
        logic       gate;
        logic [2:0] gen;
        logic [5:0] width;
        logic [7:0] bus;
    } t_ev_item;

    typedef struct packed {
        t_note            note;
        logic [CNT_W-1:0] count;
        logic [2:0]       pstate;
        logic             last;
    } t_note_rec;

    typedef struct packed {
        t_ev_item ev;
        logic     pin;
        t_note    pin_note;
        t_port_st pin_state;
    } t_step_row;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 42;
    localparam int STALL_LEN   = 60;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [2:0]       i_kind;
    logic             i_gate_ok;
    logic [2:0]       i_link_gen;
    logic [5:0]       i_link_width;
    logic [7:0]       i_bus_number;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [3:0]       o_note;
    logic [CNT_W-1:0] o_note_count;
    logic [2:0]       o_port_state;
    logic             o_last;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [5:0]       i_cfg_data;

    pcie_port_link_fsm_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_gate_ok    (i_gate_ok),
        .i_link_gen   (i_link_gen),
        .i_link_width (i_link_width),
        .i_bus_number (i_bus_number),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_note       (o_note),
        .o_note_count (o_note_count),
        .o_port_state (o_port_state),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock: period 4
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Port model state and register copies
    t_port_st         port_st;
    logic [7:0]       held_bus;
    logic [CNT_W-1:0] macup_cnt, linkup_cnt, hostup_cnt, fault_cnt;
    logic [2:0]       want_gen;
    logic [5:0]       want_width;

    t_note            step_note[$];
    logic [CNT_W-1:0] step_cnt[$];
    t_note_rec        note_fifo[$];
    t_step_row        plan_rows[$];

    int  mismatches    = 0;
    int  events_sent   = 0;
    int  notes_checked = 0;
    int  settings_used = 1;
    int  note_seen[16];
    int  quiet_cycles  = 0;
    bit  calm          = 1'b0;
    bit  hold_req      = 1'b0;

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic add_note(input t_note n, input logic [CNT_W-1:0] c);
        step_note.push_back(n);
        step_cnt.push_back(c);
    endtask

    // Invalid transition: count always, note only when leaving a good state
    task automatic raise_fault();
        fault_cnt++;
        if (port_st != P_FAULT) begin
            port_st = P_FAULT;
            add_note(NT_FAULT, fault_cnt);
        end
    endtask

    task automatic drop_link();
        add_note(NT_LINKDN, linkup_cnt);
    endtask

    task automatic drop_host();
        held_bus = 8'd0;
        add_note(NT_HOSTDN, hostup_cnt);
    endtask

    task automatic update_bus(input logic [7:0] bus);
        logic [7:0] prev;
        prev     = held_bus;
        held_bus = bus;
        if (bus != 8'd0 && bus != prev)
            add_note(NT_BUSCHG, '0);
    endtask

    // Advance the port model by one event and queue the notes it raises.
    // A pinned row replaces note and state of the first note with typed values.
    task automatic predict_event(input t_ev_item ev, input logic pin,
                                 input t_note pin_note, input t_port_st pin_state);
        t_port_st  st;
        t_note_rec rec;
        int        n;
        st = port_st;
        step_note.delete();
        step_cnt.delete();
        case (st)
            P_OFF, P_DOWN: begin
                if (ev.kind == EV_MACUP) begin
                    port_st = P_MACUP;
                    macup_cnt++;
                    add_note(NT_MACUP, macup_cnt);
                end else if (ev.kind == EV_LINKUP) begin
                    raise_fault();
                end else if (ev.kind == EV_PWRDN && st == P_DOWN) begin
                    port_st = P_OFF;
                    add_note(NT_POWERDN, '0);
                end
            end
            P_MACUP: begin
                case (ev.kind)
                    EV_MACDN: port_st = P_DOWN;
                    EV_MACUP: raise_fault();
                    EV_LINKUP: begin
                        port_st = P_LINKUP;
                        if (!ev.gate) begin
                            raise_fault();
                        end else begin
                            held_bus = ev.bus;
                            linkup_cnt++;
                            add_note(NT_LINKUP, linkup_cnt);
                            // serdes reset when the link trained below requirement
                            if ((want_gen != 0 && ev.gen < want_gen) ||
                                (want_width != 0 && ev.width < want_width))
                                add_note(NT_SERDES, '0);
                        end
                    end
                    EV_PWRDN: begin
                        port_st = P_OFF;
                        add_note(NT_POWERDN, '0);
                    end
                    default: ;
                endcase
            end
            P_LINKUP: begin
                case (ev.kind)
                    EV_MACDN: begin
                        port_st = P_DOWN;
                        drop_link();
                    end
                    EV_MACUP: raise_fault();
                    EV_LINKDN: begin
                        port_st = P_MACUP;
                        drop_link();
                    end
                    EV_BUSCHG: begin
                        port_st = P_UP;
                        update_bus(ev.bus);
                        hostup_cnt++;
                        add_note(NT_HOSTUP, hostup_cnt);
                    end
                    EV_PWRDN: begin
                        port_st = P_OFF;
                        drop_link();
                        add_note(NT_POWERDN, '0);
                    end
                    default: ;
                endcase
            end
            P_UP: begin
                case (ev.kind)
                    EV_MACDN: begin
                        port_st = P_DOWN;
                        drop_host();
                        drop_link();
                    end
                    EV_MACUP, EV_LINKUP: raise_fault();
                    EV_LINKDN: begin
                        port_st = P_MACUP;
                        drop_host();
                        drop_link();
                    end
                    EV_BUSCHG: update_bus(ev.bus);
                    EV_PWRDN: begin
                        port_st = P_OFF;
                        drop_host();
                        drop_link();
                        add_note(NT_POWERDN, '0);
                    end
                    default: ;
                endcase
            end
            default: begin
                if (ev.kind == EV_MACDN) begin
                    port_st = P_DOWN;
                end else if (ev.kind == EV_PWRDN) begin
                    port_st = P_OFF;
                    add_note(NT_POWERDN, '0);
                end
            end
        endcase
        if (step_note.size() == 0)
            add_note(NT_NONE, '0);
        n = step_note.size();
        for (int k = 0; k < n; k++) begin
            rec.note   = step_note[k];
            rec.count  = step_cnt[k];
            rec.pstate = port_st;
            rec.last   = (k == n - 1);
            if (k == 0 && pin) begin
                rec.note   = pin_note;
                rec.pstate = pin_state;
            end
            note_fifo.push_back(rec);
        end
    endtask

    // Random event, mostly the next step up the link ladder
    function automatic t_ev_item pick_event();
        t_ev_item ev;
        if ($urandom_range(0, 3) == 0) begin
            ev.kind = t_ev'($urandom_range(0, 7));
        end else begin
            case (port_st)
                P_OFF, P_DOWN: ev.kind = EV_MACUP;
                P_MACUP:       ev.kind = EV_LINKUP;
                P_LINKUP: begin
                    case ($urandom_range(0, 4))
                        0:       ev.kind = EV_MACDN;
                        1:       ev.kind = EV_LINKDN;
                        2:       ev.kind = EV_PWRDN;
                        default: ev.kind = EV_BUSCHG;
                    endcase
                end
                P_UP: begin
                    case ($urandom_range(0, 5))
                        3:       ev.kind = EV_LINKDN;
                        4:       ev.kind = EV_MACDN;
                        5:       ev.kind = EV_PWRDN;
                        default: ev.kind = EV_BUSCHG;
                    endcase
                end
                default: ev.kind = $urandom_range(0, 1) ? EV_MACDN : EV_PWRDN;
            endcase
        end
        ev.gate  = ($urandom_range(0, 9) != 0);
        ev.gen   = 3'($urandom_range(0, 7));
        ev.width = 6'($urandom_range(0, 32));
        case ($urandom_range(0, 3))
            0:       ev.bus = 8'd0;
            1:       ev.bus = held_bus;
            default: ev.bus = 8'($urandom_range(0, 255));
        endcase
        return ev;
    endfunction

    // Offer one request, wait for the handshake, then update the model
    task automatic send_event(input t_ev_item ev, input logic pin,
                              input t_note pin_note, input t_port_st pin_state);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_kind       = ev.kind;
        i_gate_ok    = ev.gate;
        i_link_gen   = ev.gen;
        i_link_width = ev.width;
        i_bus_number = ev.bus;
        do @(posedge i_clk); while (!o_in_ready);
        events_sent++;
        predict_event(ev, pin, pin_note, pin_state);
    endtask

    task automatic add_row(input t_ev kind, input logic gate, input logic [2:0] gen,
                           input logic [5:0] width, input logic [7:0] bus,
                           input logic pin, input t_note pin_note,
                           input t_port_st pin_state);
        t_step_row r;
        r.ev.kind  = kind;
        r.ev.gate  = gate;
        r.ev.gen   = gen;
        r.ev.width = width;
        r.ev.bus   = bus;
        r.pin       = pin;
        r.pin_note  = pin_note;
        r.pin_state = pin_state;
        plan_rows.push_back(r);
    endtask

    task automatic wait_drained();
        while (note_fifo.size() != 0)
            @(posedge i_clk);
    endtask

    // Quiesce the port, then write both requirement registers
    task automatic set_requirements(input logic [2:0] g, input logic [5:0] w);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_REQ_GEN;
        i_cfg_data  = {3'd0, g};
        @(negedge i_clk);
        i_cfg_index = CFG_REQ_WIDTH;
        i_cfg_data  = w;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        want_gen   = g;
        want_width = w;
        settings_used++;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin : rx_side
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Compare each notification with the oldest prediction
    always @(posedge i_clk) begin : check_notes
        t_note_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            notes_checked++;
            if (!$isunknown(o_note))
                note_seen[o_note]++;
            if (note_fifo.size() == 0) begin
                flag_error($sformatf("note %0d with nothing pending", o_note));
            end else begin
                want = note_fifo.pop_front();
                if (o_note !== want.note || o_note_count !== want.count ||
                    o_port_state !== want.pstate || o_last !== want.last)
                    flag_error($sformatf(
                        "note %0d/%0d count %0d/%0d state %0d/%0d last %0d/%0d (exp/got)",
                        want.note, o_note, want.count, o_note_count,
                        want.pstate, o_port_state, want.last, o_last));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [2:0] g;
        logic [5:0] w;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = EV_MACDN;
        i_gate_ok    = 1'b0;
        i_link_gen   = 3'd0;
        i_link_width = 6'd0;
        i_bus_number = 8'd0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_REQ_GEN;
        i_cfg_data   = 6'd0;
        port_st      = P_OFF;
        held_bus     = 8'd0;
        macup_cnt    = '0;
        linkup_cnt   = '0;
        hostup_cnt   = '0;
        fault_cnt    = '0;
        want_gen     = 3'd0;
        want_width   = 6'd0;
        foreach (note_seen[i]) note_seen[i] = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle-state events, faults, full bring-up and teardown
        add_row(EV_MACDN,  0, 0, 0,  0,   1, NT_NONE,    P_OFF);
        add_row(EV_PWRDN,  0, 0, 0,  0,   1, NT_NONE,    P_OFF);
        add_row(EV_RSVD6,  1, 7, 32, 255, 1, NT_NONE,    P_OFF);
        add_row(EV_LINKUP, 1, 0, 0,  0,   1, NT_FAULT,   P_FAULT);
        add_row(EV_MACUP,  0, 0, 0,  0,   1, NT_NONE,    P_FAULT);
        add_row(EV_PWRDN,  0, 0, 0,  0,   1, NT_POWERDN, P_OFF);
        add_row(EV_MACUP,  0, 0, 0,  0,   1, NT_MACUP,   P_MACUP);
        add_row(EV_MACUP,  0, 0, 0,  0,   1, NT_FAULT,   P_FAULT);
        add_row(EV_MACDN,  0, 0, 0,  0,   1, NT_NONE,    P_DOWN);
        add_row(EV_MACUP,  0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_LINKUP, 0, 7, 32, 255, 1, NT_FAULT,   P_FAULT);
        add_row(EV_MACDN,  0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_PWRDN,  0, 0, 0,  0,   1, NT_POWERDN, P_OFF);
        add_row(EV_MACUP,  0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_LINKUP, 1, 0, 0,  0,   1, NT_LINKUP,  P_LINKUP);
        add_row(EV_BUSCHG, 0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_BUSCHG, 0, 0, 0,  255, 1, NT_BUSCHG,  P_UP);
        add_row(EV_BUSCHG, 0, 0, 0,  255, 1, NT_NONE,    P_UP);
        add_row(EV_LINKUP, 1, 7, 32, 0,   1, NT_FAULT,   P_FAULT);
        add_row(EV_RSVD7,  0, 0, 0,  0,   1, NT_NONE,    P_FAULT);
        add_row(EV_PWRDN,  0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_MACUP,  0, 0, 0,  0,   0, NT_NONE,    P_OFF);
        add_row(EV_LINKUP, 1, 7, 32, 85,  0, NT_NONE,    P_OFF);
        add_row(EV_BUSCHG, 0, 0, 0,  170, 0, NT_NONE,    P_OFF);
        add_row(EV_PWRDN,  0, 0, 0,  0,   1, NT_HOSTDN,  P_OFF);
        foreach (plan_rows[i])
            send_event(plan_rows[i].ev, plan_rows[i].pin,
                       plan_rows[i].pin_note, plan_rows[i].pin_state);

        // Random phases, each under its own requirement setting
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin g = 3'd7; w = 6'd32; end
                1: begin g = 3'd1; w = 6'd1;  end
                2: begin g = 3'd0; w = 6'd32; end
                3: begin g = 3'd7; w = 6'd0;  end
                default: begin
                    g = 3'($urandom_range(1, 6));
                    w = 6'($urandom_range(1, 31));
                end
            endcase
            set_requirements(g, w);
            calm = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long receiver hold-off while requests keep coming
                if (p == 1 && i == 8)
                    hold_req = 1'b1;
                send_event(pick_event(), 1'b0, NT_NONE, P_OFF);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        repeat (12) @(posedge i_clk);

        $display("covered %0d port events, %0d notifications under %0d requirement settings",
                 events_sent, notes_checked, settings_used);
        $display("faults %0d, serdes resets %0d, bus changes %0d, host downs %0d",
                 note_seen[NT_FAULT], note_seen[NT_SERDES], note_seen[NT_BUSCHG],
                 note_seen[NT_HOSTDN]);
        if (mismatches == 0 && note_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcielf_pkg.sv
rtl/pcielf_front.sv
rtl/pcielf_queue.sv
rtl/pcielf_back.sv
rtl/pcie_port_link_fsm_top.sv
rtl/pcielf_checker.sv
tb/pcie_port_link_fsm_top_test.sv
